// ===== rtl/acrw_pkg.sv =====
// shared types, constants and helpers for the audio capture ring writer
package acrw_pkg;

   localparam int MAX_BUFFER_BYTES = 65536;
   localparam int UPSAMPLE_FACTOR  = 4;

   localparam int FILL_W   = 17;
   localparam int OFFSET_W = 16;
   localparam int FRAG_W   = 16;
   localparam int FRAME_W  = 14;
   localparam int DATA_W   = 32;
   localparam int BYTES_W  = 3;
   localparam int SAMPLE_W = 16;
   localparam int SIZE_W   = 5;
   localparam int LANE_W   = $clog2(UPSAMPLE_FACTOR);

   // remainder unit: one quotient bit per step
   localparam int DIV_STEPS = FILL_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

   localparam logic [SIZE_W-1:0] SIZE_RAW      = SIZE_W'(1);
   localparam logic [SIZE_W-1:0] SIZE_MONO     = SIZE_W'(2);
   localparam logic [SIZE_W-1:0] SIZE_UPSAMPLE = SIZE_W'(4 * UPSAMPLE_FACTOR);

   localparam logic [BYTES_W-1:0] BYTES_RAW  = BYTES_W'(1);
   localparam logic [BYTES_W-1:0] BYTES_MONO = BYTES_W'(2);
   localparam logic [BYTES_W-1:0] BYTES_WORD = BYTES_W'(4);
   localparam logic [BYTES_W-1:0] BYTES_NONE = BYTES_W'(0);

   localparam logic [FILL_W-1:0] BUFFER_MAX     = FILL_W'(MAX_BUFFER_BYTES);
   localparam logic [FILL_W-1:0] BUFFER_RESET   = FILL_W'(65536);
   localparam logic [FRAG_W-1:0] FRAGMENT_RESET = FRAG_W'(4096);

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      MODE_RAW      = 2'd0,
      MODE_MONO     = 2'd1,
      MODE_UPSAMPLE = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      REG_MODE     = 2'd0,
      REG_ENABLE   = 2'd1,
      REG_BUFFER   = 2'd2,
      REG_FRAGMENT = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [1:0]        mode;
      logic              enable;
      logic [FILL_W-1:0] buffer_bytes;
      logic [FRAG_W-1:0] period_bytes;
   } cfg_type;

   typedef struct packed {
      logic                                      load;
      logic [OFFSET_W-1:0]                       base;
      logic [UPSAMPLE_FACTOR-1:0][DATA_W-1:0]    words;
      logic [LANE_W-1:0]                         last_index;
      logic [BYTES_W-1:0]                        nbytes;
   } batch_type;

   typedef struct packed {
      logic               hold;
      logic               period_done;
      logic [FRAME_W-1:0] read_frame;
      logic               read_valid;
   } status_type;

   // (b - 128) * 128 as a 16-bit two's complement sample
   function automatic logic [SAMPLE_W-1:0] to_sample(input logic [7:0] b);
      return {~b[7], ~b[7], b[6:0], 7'b0};
   endfunction

endpackage

// ===== rtl/acrw_req_if.sv =====
// captured byte channel
interface acrw_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] sample_byte;

   modport source (output valid, output sample_byte, input ready);
   modport sink   (input valid, input sample_byte, output ready);
endinterface

// ===== rtl/acrw_rsp_if.sv =====
// ring write channel
interface acrw_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic [acrw_pkg::OFFSET_W-1:0]         write_offset;
   logic [acrw_pkg::DATA_W-1:0]           write_data;
   logic [acrw_pkg::BYTES_W-1:0]          write_bytes;
   logic                                  period_done;
   logic [acrw_pkg::FRAME_W-1:0]          read_frame;
   logic                                  read_valid;
   logic                                  last;

   modport source (output valid, output write_offset, output write_data, output write_bytes,
                   output period_done, output read_frame, output read_valid, output last,
                   input ready);
   modport sink   (input valid, input write_offset, input write_data, input write_bytes,
                   input period_done, input read_frame, input read_valid, input last,
                   output ready);
endinterface

// ===== rtl/acrw_csr.sv =====
// configuration register file on an apb-style port
module acrw_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [acrw_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [acrw_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [acrw_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready,
   output acrw_pkg::cfg_type                 cfg
);

   acrw_pkg::cfg_type       cfg_ff, cfg_in;
   acrw_pkg::reg_index_type index;
   logic                    write_en;

   assign csr_pready = 1'b1;
   assign index      = acrw_pkg::reg_index_type'(csr_paddr[3:2]);
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (index)
            acrw_pkg::REG_MODE:     cfg_in.mode         = csr_pwdata[1:0];
            acrw_pkg::REG_ENABLE:   cfg_in.enable       = csr_pwdata[0];
            acrw_pkg::REG_BUFFER:   cfg_in.buffer_bytes = csr_pwdata[acrw_pkg::FILL_W-1:0];
            acrw_pkg::REG_FRAGMENT: cfg_in.period_bytes = csr_pwdata[acrw_pkg::FRAG_W-1:0];
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         acrw_pkg::REG_MODE:     csr_prdata = acrw_pkg::CSR_DATA_W'(cfg_ff.mode);
         acrw_pkg::REG_ENABLE:   csr_prdata = acrw_pkg::CSR_DATA_W'(cfg_ff.enable);
         acrw_pkg::REG_BUFFER:   csr_prdata = acrw_pkg::CSR_DATA_W'(cfg_ff.buffer_bytes);
         acrw_pkg::REG_FRAGMENT: csr_prdata = acrw_pkg::CSR_DATA_W'(cfg_ff.period_bytes);
         default:                csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode         <= acrw_pkg::MODE_RAW;
         cfg_ff.enable       <= 1'b0;
         cfg_ff.buffer_bytes <= acrw_pkg::BUFFER_RESET;
         cfg_ff.period_bytes <= acrw_pkg::FRAGMENT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/acrw_rem_unit.sv =====
// iterative restoring remainder unit, one bit per cycle
module acrw_rem_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [acrw_pkg::FILL_W-1:0]     dividend,
   input  logic [acrw_pkg::FRAG_W-1:0]     divisor,
   output logic                            busy,
   output logic                            done,
   output logic [acrw_pkg::FRAG_W-1:0]     remainder
);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [acrw_pkg::DIV_CNT_W-1:0]    cnt_ff, cnt_in;
   logic [acrw_pkg::FILL_W-1:0]       dvd_ff, dvd_in;
   logic [acrw_pkg::FRAG_W-1:0]       dvs_ff, dvs_in;
   logic [acrw_pkg::FRAG_W-1:0]       rem_ff, rem_in;
   logic [acrw_pkg::FRAG_W:0]         partial;
   logic [acrw_pkg::FRAG_W:0]         diff;

   assign busy      = busy_ff;
   assign done      = done_ff;
   assign remainder = rem_ff;

   // shift in the next dividend bit, subtract when it fits
   assign partial = {rem_ff, dvd_ff[acrw_pkg::FILL_W-1]};
   assign diff    = partial - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = acrw_pkg::DIV_CNT_W'(acrw_pkg::DIV_STEPS);
         dvd_in  = dividend;
         dvs_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = (partial >= {1'b0, dvs_ff}) ? diff[acrw_pkg::FRAG_W-1:0]
                                              : partial[acrw_pkg::FRAG_W-1:0];
         dvd_in = {dvd_ff[acrw_pkg::FILL_W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == acrw_pkg::DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (rem_ff < dvs_ff))
      else $error("remainder not below divisor");

   a_busy_has_count: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (cnt_ff != '0))
      else $error("remainder unit busy with no steps left");

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !start)
      else $error("remainder unit restarted while busy");

endmodule

// ===== rtl/acrw_engine.sv =====
// input register, sample formatting and ring pointer state
module acrw_engine (
   input  logic                   clock,
   input  logic                   reset,
   acrw_req_if.sink               req_chan,
   input  acrw_pkg::cfg_type      cfg,
   input  logic                   batch_ready,
   output acrw_pkg::batch_type    batch,
   output acrw_pkg::status_type   status
);

   localparam int W = acrw_pkg::FILL_W;

   logic [7:0]                          byte_ff, byte_in;
   logic                                byte_valid_ff, byte_valid_in;
   logic [W-1:0]                        fill_ff, fill_in;
   logic [W-1:0]                        nb_ff, nb_in;
   logic [acrw_pkg::FRAME_W-1:0]        frame_ff, frame_in;
   logic                                known_ff, known_in;
   logic                                pdone_ff, pdone_in;
   logic [acrw_pkg::SAMPLE_W-1:0]       prev_ff, prev_in;
   logic                                wait_ff, wait_in;

   logic                                take;
   logic                                fire;
   logic [W-1:0]                        buf_eff;
   logic [acrw_pkg::FRAG_W-1:0]         frag;
   logic [acrw_pkg::SIZE_W-1:0]         size;
   logic                                idle;
   logic                                wrap;
   logic [W-1:0]                        fill0, nb0, fill1;
   logic                                crossed;

   logic signed [acrw_pkg::SAMPLE_W-1:0] prev_s, new_s;
   logic signed [acrw_pkg::SAMPLE_W:0]   diff_s, delta_s;
   logic [acrw_pkg::SAMPLE_W-1:0]        d1, s1, s2, s3, s4;

   logic                                div_busy, div_done;
   logic [acrw_pkg::FRAG_W-1:0]         rem;
   logic [W:0]                          nb_sum;
   logic [W-1:0]                        rd_offset;
   logic                                whole;

   assign frag    = cfg.period_bytes;
   assign buf_eff = (cfg.buffer_bytes > acrw_pkg::BUFFER_MAX) ? acrw_pkg::BUFFER_MAX
                                                              : cfg.buffer_bytes;

   always_comb begin
      case (cfg.mode)
         acrw_pkg::MODE_MONO:     size = acrw_pkg::SIZE_MONO;
         acrw_pkg::MODE_UPSAMPLE: size = acrw_pkg::SIZE_UPSAMPLE;
         default:                 size = acrw_pkg::SIZE_RAW;
      endcase
   end

   assign idle = !cfg.enable || (buf_eff == '0) || (frag == '0) || (buf_eff < W'(size));

   assign wrap    = ({1'b0, fill_ff} + (W+1)'(size)) > {1'b0, buf_eff};
   assign fill0   = wrap ? '0 : fill_ff;
   assign nb0     = wrap ? W'(frag) : nb_ff;
   assign fill1   = fill0 + W'(size);
   assign crossed = fill1 >= nb0;

   // upsample: four steps of a truncated quarter delta
   assign prev_s  = prev_ff;
   assign new_s   = acrw_pkg::to_sample(byte_ff);
   assign diff_s  = (acrw_pkg::SAMPLE_W+1)'(new_s) - (acrw_pkg::SAMPLE_W+1)'(prev_s);
   assign delta_s = (diff_s + (diff_s[acrw_pkg::SAMPLE_W] ? 17'sd3 : 17'sd0)) >>> 2;
   assign d1      = delta_s[acrw_pkg::SAMPLE_W-1:0];
   assign s1      = prev_ff + d1;
   assign s2      = prev_ff + {d1[acrw_pkg::SAMPLE_W-2:0], 1'b0};
   assign s3      = s2 + d1;
   assign s4      = prev_ff + {d1[acrw_pkg::SAMPLE_W-3:0], 2'b0};

   assign fire          = byte_valid_ff && !wait_ff && batch_ready;
   assign req_chan.ready = !byte_valid_ff || fire;
   assign take          = req_chan.valid && req_chan.ready;

   // boundary result once the remainder is in
   assign nb_sum    = {1'b0, fill_ff} - (W+1)'(rem) + (W+1)'(frag);
   assign whole     = fill_ff >= W'(frag);
   assign rd_offset = fill_ff - W'(rem) - W'(frag);

   acrw_rem_unit u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (fire && !idle && crossed),
      .dividend  (fill1),
      .divisor   (frag),
      .busy      (div_busy),
      .done      (div_done),
      .remainder (rem)
   );

   always_comb begin
      batch.load       = fire;
      batch.base       = fill_ff[acrw_pkg::OFFSET_W-1:0];
      batch.words      = '0;
      batch.last_index = '0;
      batch.nbytes     = acrw_pkg::BYTES_NONE;
      if (!idle) begin
         batch.base = fill0[acrw_pkg::OFFSET_W-1:0];
         case (cfg.mode)
            acrw_pkg::MODE_MONO: begin
               // sample in the low half, high bytes zero
               batch.words[0] = {{(acrw_pkg::DATA_W-acrw_pkg::SAMPLE_W){1'b0}}, new_s};
               batch.nbytes   = acrw_pkg::BYTES_MONO;
            end
            acrw_pkg::MODE_UPSAMPLE: begin
               batch.words[0]   = {s1, s1};
               batch.words[1]   = {s2, s2};
               batch.words[2]   = {s3, s3};
               batch.words[3]   = {s4, s4};
               batch.last_index = acrw_pkg::LANE_W'(acrw_pkg::UPSAMPLE_FACTOR - 1);
               batch.nbytes     = acrw_pkg::BYTES_WORD;
            end
            default: begin
               batch.words[0] = acrw_pkg::DATA_W'(byte_ff);
               batch.nbytes   = acrw_pkg::BYTES_RAW;
            end
         endcase
      end
   end

   assign status.hold        = wait_ff;
   assign status.period_done = pdone_ff;
   assign status.read_frame  = frame_ff;
   assign status.read_valid  = known_ff;

   always_comb begin
      byte_in       = byte_ff;
      byte_valid_in = byte_valid_ff;
      fill_in       = fill_ff;
      nb_in         = nb_ff;
      frame_in      = frame_ff;
      known_in      = known_ff;
      pdone_in      = pdone_ff;
      prev_in       = prev_ff;
      wait_in       = wait_ff;
      if (fire) begin
         byte_valid_in = 1'b0;
         pdone_in      = 1'b0;
         if (!idle) begin
            fill_in = fill1;
            nb_in   = nb0;
            wait_in = crossed;
            if (cfg.mode == acrw_pkg::MODE_UPSAMPLE) begin
               prev_in = s4;
            end
         end
      end
      if (take) begin
         byte_in       = req_chan.sample_byte;
         byte_valid_in = 1'b1;
      end
      if (div_done) begin
         wait_in  = 1'b0;
         nb_in    = (nb_sum > {1'b0, buf_eff}) ? W'(frag) : nb_sum[W-1:0];
         known_in = whole;
         pdone_in = whole;
         frame_in = whole ? rd_offset[acrw_pkg::OFFSET_W-1:2] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_valid_ff <= 1'b0;
         fill_ff       <= '0;
         nb_ff         <= W'(acrw_pkg::FRAGMENT_RESET);
         frame_ff      <= '0;
         known_ff      <= 1'b0;
         pdone_ff      <= 1'b0;
         prev_ff       <= '0;
         wait_ff       <= 1'b0;
      end else begin
         byte_valid_ff <= byte_valid_in;
         fill_ff       <= fill_in;
         nb_ff         <= nb_in;
         frame_ff      <= frame_in;
         known_ff      <= known_in;
         pdone_ff      <= pdone_in;
         prev_ff       <= prev_in;
         wait_ff       <= wait_in;
      end
      byte_ff <= byte_in;
   end

   a_done_only_waiting: assert property (@(posedge clock) disable iff (reset)
      div_done |-> wait_ff)
      else $error("remainder returned with no boundary pending");

   a_wait_tracks_unit: assert property (@(posedge clock) disable iff (reset)
      (wait_ff && !div_done) |-> div_busy)
      else $error("boundary pending with remainder unit idle");

   a_fill_held_while_waiting: assert property (@(posedge clock) disable iff (reset)
      (wait_ff && $past(wait_ff)) |-> $stable(fill_ff))
      else $error("fill moved during boundary update");

   a_fill_in_ring: assert property (@(posedge clock) disable iff (reset)
      $past(fire && !idle) |-> (fill_ff <= $past(buf_eff)))
      else $error("fill passed buffer end");

endmodule

// ===== rtl/acrw_serializer.sv =====
// result register that hands out one ring write per cycle while rsp_chan is ready and no boundary update holds it
module acrw_serializer (
   input  logic                   clock,
   input  logic                   reset,
   input  acrw_pkg::batch_type    batch,
   input  acrw_pkg::status_type   status,
   output logic                   batch_ready,
   acrw_rsp_if.source             rsp_chan
);

   logic                                              active_ff, active_in;
   logic [acrw_pkg::LANE_W-1:0]                       idx_ff, idx_in;
   logic [acrw_pkg::LANE_W-1:0]                       last_idx_ff, last_idx_in;
   logic [acrw_pkg::OFFSET_W-1:0]                     base_ff, base_in;
   logic [acrw_pkg::UPSAMPLE_FACTOR-1:0][acrw_pkg::DATA_W-1:0] words_ff, words_in;
   logic [acrw_pkg::BYTES_W-1:0]                      nbytes_ff, nbytes_in;
   logic                                              pop;
   logic                                              is_last;

   assign is_last     = idx_ff == last_idx_ff;
   assign pop         = rsp_chan.valid && rsp_chan.ready;
   assign batch_ready = !active_ff || (pop && is_last);

   assign rsp_chan.valid        = active_ff && !status.hold;
   assign rsp_chan.write_offset = base_ff + {{(acrw_pkg::OFFSET_W-acrw_pkg::LANE_W-2){1'b0}},
                                             idx_ff, 2'b00};
   assign rsp_chan.write_data   = words_ff[idx_ff];
   assign rsp_chan.write_bytes  = nbytes_ff;
   assign rsp_chan.period_done  = is_last && status.period_done;
   assign rsp_chan.read_frame   = status.read_frame;
   assign rsp_chan.read_valid   = status.read_valid;
   assign rsp_chan.last         = is_last;

   always_comb begin
      active_in   = active_ff;
      idx_in      = idx_ff;
      last_idx_in = last_idx_ff;
      base_in     = base_ff;
      words_in    = words_ff;
      nbytes_in   = nbytes_ff;
      if (pop) begin
         if (is_last) begin
            active_in = 1'b0;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
      if (batch.load) begin
         active_in   = 1'b1;
         idx_in      = '0;
         last_idx_in = batch.last_index;
         base_in     = batch.base;
         words_in    = batch.words;
         nbytes_in   = batch.nbytes;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         idx_ff    <= '0;
      end else begin
         active_ff <= active_in;
         idx_ff    <= idx_in;
      end
      last_idx_ff <= last_idx_in;
      base_ff     <= base_in;
      words_ff    <= words_in;
      nbytes_ff   <= nbytes_in;
   end

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      batch.load |-> batch_ready)
      else $error("batch loaded over undelivered writes");

   a_mid_batch_stays: assert property (@(posedge clock) disable iff (reset)
      (pop && !is_last) |=> (active_ff && idx_ff == $past(idx_ff) + 1'b1))
      else $error("batch dropped before its last write");

   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (idx_ff <= last_idx_ff))
      else $error("write index past end of batch");

endmodule

// ===== rtl/audio_capture_ring_writer.sv =====
// top level of the audio capture ring writer
//
//   channel   dir   handshake                 transaction
//   req_chan  in    valid/ready               one captured byte
//   rsp_chan  out   valid/ready               one ring write (offset, data, pointer status)
//   csr_*     in    apb setup/access, pready  one register write or read
//
// raw and mono bytes make one write each and can follow back to back; an upsampled byte makes
// four writes and holds the result port until the last of them is taken
// reaching a fragment boundary holds the result port while the remainder unit finds
// fill mod period size, one bit per cycle
// a byte passes through the input reg and then the result reg before its first write
// synchronous reset sets pointers, previous sample and control registers to their reset values; no clearing pass
// a stall on rsp_chan backs up into req_chan after one buffered byte
module audio_capture_ring_writer (
   input  logic                              clock,
   input  logic                              reset,
   acrw_req_if.sink                          req_chan,
   acrw_rsp_if.source                        rsp_chan,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [acrw_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [acrw_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [acrw_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   acrw_pkg::cfg_type      cfg;
   acrw_pkg::batch_type    batch;
   acrw_pkg::status_type   status;
   logic                   batch_ready;

   // mode, enable, buffer and fragment sizes
   acrw_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // byte register, formatting into a batch of writes, fill and read pointers
   acrw_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .cfg         (cfg),
      .batch_ready (batch_ready),
      .batch       (batch),
      .status      (status)
   );

   // holds one batch and hands its writes out in order; held back while
   // the boundary update is still running
   acrw_serializer u_serializer (
      .clock       (clock),
      .reset       (reset),
      .batch       (batch),
      .status      (status),
      .batch_ready (batch_ready),
      .rsp_chan    (rsp_chan)
   );

endmodule
